FILE: hw/rtl/rcsn_pkg.sv
`default_nettype none

package rcsn_pkg;

  localparam int CARRY_W = 11;
  localparam int DIV_W = 10;
  localparam int INTERVAL_W = 16;
  localparam int CAP_W = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NOTCH_W = 8;

  typedef enum logic [1:0] {
    OP_MOTION_H = 2'd0,
    OP_MOTION_V = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIVISOR_H = 3'd0,
    REG_DIVISOR_V = 3'd1,
    REG_INTERVAL  = 3'd2,
    REG_MAX_DUMP  = 3'd3,
    REG_FLIP_H    = 3'd4,
    REG_FLIP_V    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic accum;
    logic tick;
    logic show_h;
    logic show_v;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic fire;
    logic held_h_nz;
    logic held_v_nz;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rcsn_ctrl.sv
`default_nettype none

module rcsn_ctrl
  import rcsn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] op,
  output logic            notch_valid,
  input  wire logic       notch_stall,
  output ctrl_cmd_t       cmd,
  input  wire ctrl_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_TICK,
    ST_SHOW,
    ST_OUT_H,
    ST_OUT_V
  } state_t;

  state_t state;
  state_t state_next;
  logic   valid_next;
  logic   accept;

  assign item_stall = (state != ST_IDLE);
  assign accept = item_valid && !item_stall;

  always_comb begin
    state_next = state;
    valid_next = notch_valid;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (op_t'(op))
            OP_MOTION_H, OP_MOTION_V: state_next = ST_DIV;
            OP_TICK: state_next = ST_TICK;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_ACC;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TICK: begin
        cmd.tick = 1'b1;
        state_next = stat.fire ? ST_SHOW : ST_IDLE;
      end
      ST_SHOW: begin
        priority if (stat.held_h_nz) begin
          cmd.show_h = 1'b1;
          valid_next = 1'b1;
          state_next = ST_OUT_H;
        end else if (stat.held_v_nz) begin
          cmd.show_v = 1'b1;
          valid_next = 1'b1;
          state_next = ST_OUT_V;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT_H: begin
        if (!notch_stall) begin
          if (stat.held_v_nz) begin
            cmd.show_v = 1'b1;
            state_next = ST_OUT_V;
          end else begin
            valid_next = 1'b0;
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT_V: begin
        if (!notch_stall) begin
          valid_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        valid_next = 1'b0;
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      notch_valid <= 1'b0;
    end else begin
      state <= state_next;
      notch_valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rcsn_datapath.sv
`default_nettype none

module rcsn_datapath
  import rcsn_pkg::*;
#(
  parameter int MOTION_BITS = 16,
  parameter int PENDING_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    op,
  input  wire logic signed [MOTION_BITS-1:0] amount,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire ctrl_cmd_t                     cmd,
  output ctrl_stat_t                         stat,
  output logic                               wheel_axis,
  output logic signed [NOTCH_W-1:0]          notches,
  output logic                               last
);

  localparam int SUM_W = ((MOTION_BITS > CARRY_W) ? MOTION_BITS : CARRY_W) + 1;
  localparam int ACC_W = ((SUM_W + 1 > PENDING_BITS) ? SUM_W + 1 : PENDING_BITS) + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam logic signed [PENDING_BITS-1:0] PEND_MAX = {1'b0, {(PENDING_BITS-1){1'b1}}};
  localparam logic signed [PENDING_BITS-1:0] PEND_MIN = {1'b1, {(PENDING_BITS-1){1'b0}}};

  logic [DIV_W-1:0]        divisor_h;
  logic [DIV_W-1:0]        divisor_v;
  logic [INTERVAL_W-1:0]   interval;
  logic [CAP_W-1:0]        max_dump;
  logic                    flip_h;
  logic                    flip_v;

  logic signed [CARRY_W-1:0]      carry_h;
  logic signed [CARRY_W-1:0]      carry_v;
  logic signed [PENDING_BITS-1:0] pend_h;
  logic signed [PENDING_BITS-1:0] pend_v;
  logic [INTERVAL_W-1:0]          countdown;
  logic                           armed;

  logic                    axis;
  logic                    neg;
  logic [DIV_W-1:0]        dvs;
  logic [DIV_W-1:0]        rem;
  logic [SUM_W-1:0]        quo;
  logic [CNT_W-1:0]        count;
  logic signed [NOTCH_W-1:0] held_h;
  logic signed [NOTCH_W-1:0] held_v;

  logic signed [CARRY_W-1:0]      carry_sel;
  logic signed [SUM_W-1:0]        sum_in;
  logic [SUM_W-1:0]               sum_mag;
  logic [DIV_W-1:0]               dvs_in;
  logic [DIV_W:0]                 shifted;
  logic signed [SUM_W:0]          quo_s;
  logic signed [CARRY_W-1:0]      rem_s;
  logic signed [PENDING_BITS-1:0] pend_sel;
  logic signed [PENDING_BITS-1:0] pend_other;
  logic signed [ACC_W-1:0]        pend_sum;
  logic signed [PENDING_BITS-1:0] pend_new;
  logic [INTERVAL_W-1:0]          arm_val;
  logic [CAP_W-1:0]               cap;
  logic signed [NOTCH_W-1:0]      dump_h;
  logic signed [NOTCH_W-1:0]      dump_v;
  logic signed [PENDING_BITS-1:0] pend_h_left;
  logic signed [PENDING_BITS-1:0] pend_v_left;

  function automatic logic signed [NOTCH_W-1:0] clamp_cap(
    input logic signed [PENDING_BITS-1:0] v,
    input logic [CAP_W-1:0] c
  );
    logic signed [PENDING_BITS-1:0] cx;
    logic signed [PENDING_BITS-1:0] res;
    cx = $signed(PENDING_BITS'(c));
    if (v > cx) begin
      res = cx;
    end else if (v < -cx) begin
      res = -cx;
    end else begin
      res = v;
    end
    return res[NOTCH_W-1:0];
  endfunction

  assign carry_sel = op[0] ? carry_v : carry_h;
  assign sum_in = SUM_W'(carry_sel) + SUM_W'(amount);
  assign sum_mag = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
  assign dvs_in = op[0] ? ((divisor_v == '0) ? DIV_W'(1) : divisor_v)
                        : ((divisor_h == '0) ? DIV_W'(1) : divisor_h);
  assign shifted = {rem, quo[SUM_W-1]};

  assign quo_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign rem_s = neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
  assign pend_sel = axis ? pend_v : pend_h;
  assign pend_other = axis ? pend_h : pend_v;
  assign pend_sum = ACC_W'(pend_sel) + ACC_W'(quo_s);

  always_comb begin
    priority if (pend_sum > ACC_W'(PEND_MAX)) begin
      pend_new = PEND_MAX;
    end else if (pend_sum < ACC_W'(PEND_MIN)) begin
      pend_new = PEND_MIN;
    end else begin
      pend_new = pend_sum[PENDING_BITS-1:0];
    end
  end

  assign arm_val = (interval == '0) ? INTERVAL_W'(1) : interval;
  assign cap = (max_dump == '0) ? CAP_W'(1) : max_dump;
  assign dump_h = clamp_cap(pend_h, cap);
  assign dump_v = clamp_cap(pend_v, cap);
  assign pend_h_left = pend_h - PENDING_BITS'(dump_h);
  assign pend_v_left = pend_v - PENDING_BITS'(dump_v);

  assign stat.div_done = (count == CNT_W'(SUM_W));
  assign stat.fire = armed && (countdown < INTERVAL_W'(2));
  assign stat.held_h_nz = (held_h != '0);
  assign stat.held_v_nz = (held_v != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_h <= DIV_W'(8);
      divisor_v <= DIV_W'(8);
      interval <= INTERVAL_W'(10);
      max_dump <= CAP_W'(3);
      flip_h <= 1'b0;
      flip_v <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIVISOR_H: divisor_h <= cfg_data[DIV_W-1:0];
        REG_DIVISOR_V: divisor_v <= cfg_data[DIV_W-1:0];
        REG_INTERVAL: interval <= cfg_data[INTERVAL_W-1:0];
        REG_MAX_DUMP: max_dump <= cfg_data[CAP_W-1:0];
        REG_FLIP_H: flip_h <= cfg_data[0];
        REG_FLIP_V: flip_v <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_h <= '0;
      carry_v <= '0;
      pend_h <= '0;
      pend_v <= '0;
      countdown <= '0;
      armed <= 1'b0;
      held_h <= '0;
      held_v <= '0;
    end else if (cmd.accum) begin
      if (axis) begin
        carry_v <= rem_s;
        pend_v <= pend_new;
      end else begin
        carry_h <= rem_s;
        pend_h <= pend_new;
      end
      if (!armed && (pend_new != '0 || pend_other != '0)) begin
        armed <= 1'b1;
        countdown <= arm_val;
      end
    end else if (cmd.tick && armed) begin
      if (countdown > INTERVAL_W'(1)) begin
        countdown <= countdown - INTERVAL_W'(1);
      end else begin
        pend_h <= pend_h_left;
        pend_v <= pend_v_left;
        armed <= (pend_h_left != '0) || (pend_v_left != '0);
        countdown <= ((pend_h_left != '0) || (pend_v_left != '0)) ? arm_val : '0;
        held_h <= flip_h ? -dump_h : dump_h;
        held_v <= flip_v ? -dump_v : dump_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.step) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      axis <= op[0];
      neg <= sum_in[SUM_W-1];
      dvs <= dvs_in;
      rem <= '0;
      quo <= sum_mag;
    end else if (cmd.step) begin
      if (shifted >= {1'b0, dvs}) begin
        rem <= DIV_W'(shifted - {1'b0, dvs});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show_h) begin
      wheel_axis <= 1'b0;
      notches <= held_h;
      last <= (held_v == '0);
    end else if (cmd.show_v) begin
      wheel_axis <= 1'b1;
      notches <= held_v;
      last <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rate_capped_scroll_notcher_core.sv
`default_nettype none

// Channel    Handshake                  Payload
// item       item_valid / item_stall    op, amount
// notch      notch_valid / notch_stall  wheel_axis, notches, last
// cfg        cfg_we                     cfg_index, cfg_data
//
// A motion request runs the serial restoring divider, one quotient bit per cycle, over the
// sum of the amount and the axis carry, then adds the quotient to that axis's pending count.
// A tick steps the countdown; a dump shows one notch result per axis with a nonzero one, h first.
// Reset is synchronous; after it the block takes requests at once.
// The block takes one request at a time and holds item_stall until its results are taken.

module rate_capped_scroll_notcher_core
  import rcsn_pkg::*;
#(
  parameter int MOTION_BITS = 16,
  parameter int PENDING_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    op,
  input  wire logic signed [MOTION_BITS-1:0] amount,
  output logic                               notch_valid,
  input  wire logic                          notch_stall,
  output logic                               wheel_axis,
  output logic signed [NOTCH_W-1:0]          notches,
  output logic                               last,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  rcsn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .op          (op),
    .notch_valid (notch_valid),
    .notch_stall (notch_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  rcsn_datapath #(
    .MOTION_BITS  (MOTION_BITS),
    .PENDING_BITS (PENDING_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .amount     (amount),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .wheel_axis (wheel_axis),
    .notches    (notches),
    .last       (last)
  );

endmodule

`default_nettype wire
